@@ design/jse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package jse_pkg;

    // micro-program address
    typedef logic [4:0] t_uaddr;

    localparam t_uaddr UA_IDLE  = 5'd0;
    localparam t_uaddr UA_OPEN  = 5'd1;
    localparam t_uaddr UA_DISP  = 5'd2;
    localparam t_uaddr UA_RAW   = 5'd3;
    localparam t_uaddr UA_ESC   = 5'd4;
    localparam t_uaddr UA_CTRL  = 5'd6;
    localparam t_uaddr UA_REPL  = 5'd12;
    localparam t_uaddr UA_PASS  = 5'd18;
    localparam t_uaddr UA_KEEP  = 5'd19;
    localparam t_uaddr UA_CLOSE = 5'd20;
    localparam t_uaddr UA_DONE  = 5'd21;

    // byte source of an emitting step
    typedef logic [2:0] t_src;
    localparam t_src SRC_CONST = 3'd0;
    localparam t_src SRC_HEAD  = 3'd1;
    localparam t_src SRC_ESC   = 3'd2;
    localparam t_src SRC_HEXHI = 3'd3;
    localparam t_src SRC_HEXLO = 3'd4;

    // constant characters
    typedef logic [2:0] t_kst;
    localparam t_kst K_QUOTE = 3'd0;
    localparam t_kst K_BSL   = 3'd1;
    localparam t_kst K_U     = 3'd2;
    localparam t_kst K_ZERO  = 3'd3;
    localparam t_kst K_F     = 3'd4;
    localparam t_kst K_D     = 3'd5;

    // sequencing
    typedef logic [2:0] t_seq;
    localparam t_seq SEQ_WAIT = 3'd0;
    localparam t_seq SEQ_NEXT = 3'd1;
    localparam t_seq SEQ_JUMP = 3'd2;
    localparam t_seq SEQ_DISP = 3'd3;
    localparam t_seq SEQ_LOOP = 3'd4;

    // side actions
    typedef logic [2:0] t_act;
    localparam t_act ACT_NONE  = 3'd0;
    localparam t_act ACT_OPEN  = 3'd1;
    localparam t_act ACT_CLOSE = 3'd2;
    localparam t_act ACT_SAVE  = 3'd3;
    localparam t_act ACT_FLUSH = 3'd4;

    // head byte classes for dispatch
    typedef logic [2:0] t_cls;
    localparam t_cls CLS_EMPTY = 3'd0;
    localparam t_cls CLS_RAW   = 3'd1;
    localparam t_cls CLS_ESC   = 3'd2;
    localparam t_cls CLS_CTRL  = 3'd3;
    localparam t_cls CLS_REPL  = 3'd4;
    localparam t_cls CLS_PASS  = 3'd5;
    localparam t_cls CLS_KEEP  = 3'd6;

    typedef struct packed {
        logic   emit;
        t_src   src;
        t_kst   kst;
        logic   pop;
        t_seq   seq;
        t_act   act;
        t_uaddr tgt;
    } t_uword;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;

    localparam logic [7:0] LEAD_E0 = 8'he0;
    localparam logic [7:0] LEAD_ED = 8'hed;
    localparam logic [7:0] LEAD_F0 = 8'hf0;
    localparam logic [7:0] LEAD_F4 = 8'hf4;

    function automatic t_uword uw(input logic e, input t_src s, input t_kst k,
                                  input logic p, input t_seq q, input t_act a,
                                  input t_uaddr t);
        t_uword w;
        w.emit = e;
        w.src  = s;
        w.kst  = k;
        w.pop  = p;
        w.seq  = q;
        w.act  = a;
        w.tgt  = t;
        return w;
    endfunction

    // control store
    function automatic t_uword uc_rom(input t_uaddr a);
        t_uword w;
        case (a)
            5'd0:    w = uw(1'b0, SRC_CONST, K_QUOTE, 1'b0, SEQ_WAIT, ACT_NONE,  UA_IDLE);
            5'd1:    w = uw(1'b1, SRC_CONST, K_QUOTE, 1'b0, SEQ_JUMP, ACT_OPEN,  UA_DISP);
            5'd2:    w = uw(1'b0, SRC_CONST, K_QUOTE, 1'b0, SEQ_DISP, ACT_NONE,  UA_DISP);
            5'd3:    w = uw(1'b1, SRC_HEAD,  K_QUOTE, 1'b1, SEQ_JUMP, ACT_NONE,  UA_DISP);
            5'd4:    w = uw(1'b1, SRC_CONST, K_BSL,   1'b0, SEQ_NEXT, ACT_NONE,  UA_DISP);
            5'd5:    w = uw(1'b1, SRC_ESC,   K_QUOTE, 1'b1, SEQ_JUMP, ACT_NONE,  UA_DISP);
            5'd6:    w = uw(1'b1, SRC_CONST, K_BSL,   1'b0, SEQ_NEXT, ACT_NONE,  UA_DISP);
            5'd7:    w = uw(1'b1, SRC_CONST, K_U,     1'b0, SEQ_NEXT, ACT_NONE,  UA_DISP);
            5'd8:    w = uw(1'b1, SRC_CONST, K_ZERO,  1'b0, SEQ_NEXT, ACT_NONE,  UA_DISP);
            5'd9:    w = uw(1'b1, SRC_CONST, K_ZERO,  1'b0, SEQ_NEXT, ACT_NONE,  UA_DISP);
            5'd10:   w = uw(1'b1, SRC_HEXHI, K_QUOTE, 1'b0, SEQ_NEXT, ACT_NONE,  UA_DISP);
            5'd11:   w = uw(1'b1, SRC_HEXLO, K_QUOTE, 1'b1, SEQ_JUMP, ACT_NONE,  UA_DISP);
            5'd12:   w = uw(1'b1, SRC_CONST, K_BSL,   1'b0, SEQ_NEXT, ACT_NONE,  UA_DISP);
            5'd13:   w = uw(1'b1, SRC_CONST, K_U,     1'b0, SEQ_NEXT, ACT_NONE,  UA_DISP);
            5'd14:   w = uw(1'b1, SRC_CONST, K_F,     1'b0, SEQ_NEXT, ACT_NONE,  UA_DISP);
            5'd15:   w = uw(1'b1, SRC_CONST, K_F,     1'b0, SEQ_NEXT, ACT_NONE,  UA_DISP);
            5'd16:   w = uw(1'b1, SRC_CONST, K_F,     1'b0, SEQ_NEXT, ACT_NONE,  UA_DISP);
            5'd17:   w = uw(1'b1, SRC_CONST, K_D,     1'b1, SEQ_JUMP, ACT_NONE,  UA_DISP);
            5'd18:   w = uw(1'b1, SRC_HEAD,  K_QUOTE, 1'b1, SEQ_LOOP, ACT_NONE,  UA_DISP);
            5'd19:   w = uw(1'b0, SRC_CONST, K_QUOTE, 1'b0, SEQ_JUMP, ACT_SAVE,  UA_DONE);
            5'd20:   w = uw(1'b1, SRC_CONST, K_QUOTE, 1'b0, SEQ_JUMP, ACT_CLOSE, UA_DONE);
            5'd21:   w = uw(1'b0, SRC_CONST, K_QUOTE, 1'b0, SEQ_JUMP, ACT_FLUSH, UA_IDLE);
            default: w = uw(1'b0, SRC_CONST, K_QUOTE, 1'b0, SEQ_JUMP, ACT_NONE,  UA_IDLE);
        endcase
        return w;
    endfunction

    function automatic logic [7:0] kst_char(input t_kst k);
        logic [7:0] c;
        case (k)
            K_QUOTE: c = CH_QUOTE;
            K_BSL:   c = CH_BSL;
            K_U:     c = CH_U;
            K_ZERO:  c = CH_ZERO;
            K_F:     c = CH_F;
            K_D:     c = CH_D;
            default: c = CH_QUOTE;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = CH_ZERO + {4'd0, n};
        end else begin
            c = CH_LA + {4'd0, n} - 8'd10;
        end
        return c;
    endfunction

    // two-character escape letter, zero when the byte has none
    function automatic logic [7:0] esc_char(input logic [7:0] b);
        logic [7:0] c;
        case (b)
            CH_QUOTE: c = CH_QUOTE;
            CH_BSL:   c = CH_BSL;
            CH_SLASH: c = CH_SLASH;
            8'h08:    c = CH_B;
            8'h0c:    c = CH_F;
            8'h0a:    c = CH_N;
            8'h0d:    c = CH_R;
            8'h09:    c = CH_T;
            default:  c = 8'h00;
        endcase
        return c;
    endfunction

    // whole sequence length for a lead byte, zero when it cannot lead
    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] n;
        if (lead inside {[8'hc2:8'hdf]}) begin
            n = 3'd2;
        end else if (lead inside {[8'he0:8'hef]}) begin
            n = 3'd3;
        end else if (lead inside {[8'hf0:8'hf4]}) begin
            n = 3'd4;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

    function automatic logic cont_ok(input logic [7:0] lead, input logic first,
                                     input logic [7:0] b);
        logic ok;
        ok = (b[7:6] == 2'b10);
        if (first) begin
            if (lead == LEAD_E0) begin
                ok = (b[7:5] == 3'b101);
            end else if (lead == LEAD_ED) begin
                ok = (b[7:5] == 3'b100);
            end else if (lead == LEAD_F0) begin
                ok = (b[7:6] == 2'b10) && (b[5:4] != 2'b00);
            end else if (lead == LEAD_F4) begin
                ok = (b[7:4] == 4'h8);
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

@@ design/json_string_escaper_utf8.sv @@
`timescale 1ns / 1ps
`default_nettype none

// JSON string escaper with UTF-8 checking. Each slave item is either one byte
// of a string (tuser 0) or the end of the string (tuser 1); the master side
// carries the quoted, escaped JSON text one byte per item, with tlast on the
// last byte caused by each input item (an input byte that only extends a
// pending UTF-8 sequence causes none). The opening quote goes out ahead of
// the first byte of a string, the closing quote at the end marker. Work is
// done by a micro-programmed sequencer: a control store of 22 words steps a
// small byte queue (pending bytes plus the new one) through dispatch,
// plain-copy, escape, \u00hh, \ufffd and UTF-8 pass-through routines. One
// item is taken at a time: after the accept comes the opening quote when a
// string starts, then per queued byte a dispatch step plus one step per
// output byte of its routine (raw emits 1 byte, a short escape 2, \u00hh
// or \ufffd 6, a UTF-8 sequence 2 to 4), then a dispatch on the empty queue
// (or a save of an unfinished UTF-8 sequence), the closing quote at an end
// marker and a step that hands over the held last byte. Output back-pressure
// stalls the sequencer on whichever step needs to emit or to flush a held byte.

module json_string_escaper_utf8 (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_tvalid,
    output logic       o_s_tready,
    input  wire  [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire        i_s_tuser,   // [0] req_type: 0 byte, 1 end of string
    output logic       o_m_tvalid,
    input  wire        i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast    // run_last
);

    // persistent string state
    logic [7:0] r_pend [3];
    logic [1:0] r_pcnt;
    logic       r_instr;

    // working queue of the current item, head at index 0
    logic [7:0] r_q [4];
    logic [2:0] r_qn;
    logic       r_fin;
    logic [2:0] r_rem;

    // sequencer
    jse_pkg::t_uaddr r_upc;

    // one-byte hold so tlast is known when the next byte is produced
    logic [7:0] r_hold;
    logic       r_hold_v;

    // output register
    logic [7:0] r_out;
    logic       r_out_last;
    logic       r_out_v;

    logic [7:0]      n_pend [3];
    logic [1:0]      n_pcnt;
    logic            n_instr;
    logic [7:0]      n_q [4];
    logic [2:0]      n_qn;
    logic            n_fin;
    logic [2:0]      n_rem;
    jse_pkg::t_uaddr n_upc;
    logic [7:0]      n_hold;
    logic            n_hold_v;
    logic [7:0]      n_out;
    logic            n_out_last;
    logic            n_out_v;

    jse_pkg::t_uword uword;
    jse_pkg::t_cls   cls;
    jse_pkg::t_uaddr disp_tgt;
    logic [7:0]      head;
    logic [7:0]      head_esc;
    logic [2:0]      need;
    logic            bad;
    logic [7:0]      emit_byte;
    logic            out_free;
    logic            stall;
    logic            accept;

    assign uword    = jse_pkg::uc_rom(r_upc);
    assign head     = r_q[0];
    assign head_esc = jse_pkg::esc_char(head);
    assign need     = jse_pkg::seq_len(head);

    // a continuation byte that is present but does not fit breaks the lead
    assign bad = ((r_qn > 3'd1) && (need > 3'd1) && !jse_pkg::cont_ok(head, 1'b1, r_q[1]))
              || ((r_qn > 3'd2) && (need > 3'd2) && !jse_pkg::cont_ok(head, 1'b0, r_q[2]))
              || ((r_qn > 3'd3) && (need > 3'd3) && !jse_pkg::cont_ok(head, 1'b0, r_q[3]));

    always_comb begin
        if (r_qn == 3'd0) begin
            cls = jse_pkg::CLS_EMPTY;
        end else if (!head[7]) begin
            if (head_esc != 8'h00) begin
                cls = jse_pkg::CLS_ESC;
            end else if (head < 8'h20) begin
                cls = jse_pkg::CLS_CTRL;
            end else begin
                cls = jse_pkg::CLS_RAW;
            end
        end else if (need == 3'd0) begin
            cls = jse_pkg::CLS_REPL;
        end else if (bad || ((r_qn < need) && r_fin)) begin
            cls = jse_pkg::CLS_REPL;
        end else if (r_qn >= need) begin
            cls = jse_pkg::CLS_PASS;
        end else begin
            cls = jse_pkg::CLS_KEEP;
        end
    end

    always_comb begin
        case (cls)
            jse_pkg::CLS_EMPTY: disp_tgt = r_fin ? jse_pkg::UA_CLOSE : jse_pkg::UA_DONE;
            jse_pkg::CLS_RAW:   disp_tgt = jse_pkg::UA_RAW;
            jse_pkg::CLS_ESC:   disp_tgt = jse_pkg::UA_ESC;
            jse_pkg::CLS_CTRL:  disp_tgt = jse_pkg::UA_CTRL;
            jse_pkg::CLS_REPL:  disp_tgt = jse_pkg::UA_REPL;
            jse_pkg::CLS_PASS:  disp_tgt = jse_pkg::UA_PASS;
            jse_pkg::CLS_KEEP:  disp_tgt = jse_pkg::UA_KEEP;
            default:            disp_tgt = jse_pkg::UA_DONE;
        endcase
    end

    always_comb begin
        case (uword.src)
            jse_pkg::SRC_CONST: emit_byte = jse_pkg::kst_char(uword.kst);
            jse_pkg::SRC_HEAD:  emit_byte = head;
            jse_pkg::SRC_ESC:   emit_byte = head_esc;
            jse_pkg::SRC_HEXHI: emit_byte = jse_pkg::hex_char(head[7:4]);
            jse_pkg::SRC_HEXLO: emit_byte = jse_pkg::hex_char(head[3:0]);
            default:            emit_byte = head;
        endcase
    end

    assign out_free   = !r_out_v || i_m_tready;
    // emitting or flushing with a held byte needs room in the output register
    assign stall      = (uword.emit || (uword.act == jse_pkg::ACT_FLUSH))
                        && r_hold_v && !out_free;
    assign o_s_tready = (r_upc == jse_pkg::UA_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_pend     = r_pend;
        n_pcnt     = r_pcnt;
        n_instr    = r_instr;
        n_q        = r_q;
        n_qn       = r_qn;
        n_fin      = r_fin;
        n_rem      = r_rem;
        n_upc      = r_upc;
        n_hold     = r_hold;
        n_hold_v   = r_hold_v;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_v    = r_out_v && !i_m_tready;

        if (accept) begin
            // pending bytes first, then the new byte behind them
            for (int i = 0; i < 3; i++) begin
                n_q[i] = (2'(i) < r_pcnt) ? r_pend[i] : i_s_tdata;
            end
            n_q[3] = i_s_tdata;
            n_qn   = {1'b0, r_pcnt} + {2'b00, !i_s_tuser};
            n_fin  = i_s_tuser;
            n_pcnt = 2'd0;
            n_upc  = r_instr ? jse_pkg::UA_DISP : jse_pkg::UA_OPEN;
        end else if (!stall && (uword.seq != jse_pkg::SEQ_WAIT)) begin
            if (uword.emit) begin
                if (r_hold_v) begin
                    n_out      = r_hold;
                    n_out_last = 1'b0;
                    n_out_v    = 1'b1;
                end
                n_hold   = emit_byte;
                n_hold_v = 1'b1;
            end

            if (uword.pop) begin
                n_q[0] = r_q[1];
                n_q[1] = r_q[2];
                n_q[2] = r_q[3];
                n_qn   = r_qn - 3'd1;
            end

            case (uword.act)
                jse_pkg::ACT_OPEN:  n_instr = 1'b1;
                jse_pkg::ACT_CLOSE: n_instr = 1'b0;
                jse_pkg::ACT_SAVE: begin
                    n_pend[0] = r_q[0];
                    n_pend[1] = r_q[1];
                    n_pend[2] = r_q[2];
                    n_pcnt    = r_qn[1:0];
                end
                jse_pkg::ACT_FLUSH: begin
                    if (r_hold_v) begin
                        n_out      = r_hold;
                        n_out_last = 1'b1;
                        n_out_v    = 1'b1;
                        n_hold_v   = 1'b0;
                    end
                end
                default: begin
                end
            endcase

            case (uword.seq)
                jse_pkg::SEQ_NEXT: n_upc = r_upc + 5'd1;
                jse_pkg::SEQ_JUMP: n_upc = uword.tgt;
                jse_pkg::SEQ_DISP: begin
                    n_upc = disp_tgt;
                    n_rem = need;
                end
                jse_pkg::SEQ_LOOP: begin
                    // copy a whole UTF-8 sequence, one byte per step
                    n_rem = r_rem - 3'd1;
                    n_upc = (r_rem == 3'd1) ? uword.tgt : r_upc;
                end
                default: n_upc = r_upc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc    <= jse_pkg::UA_IDLE;
            r_pcnt   <= 2'd0;
            r_instr  <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_upc    <= n_upc;
            r_pcnt   <= n_pcnt;
            r_instr  <= n_instr;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend     <= n_pend;
        r_q        <= n_q;
        r_qn       <= n_qn;
        r_fin      <= n_fin;
        r_rem      <= n_rem;
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ design/jse_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jse_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_s_tvalid,
    input wire       o_s_tready,
    input wire [7:0] i_s_tdata,
    input wire       i_s_tuser,
    input wire       o_m_tvalid,
    input wire       i_m_tready,
    input wire [7:0] o_m_tdata,
    input wire       o_m_tlast
);

    // stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("output item changed while stalled");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while previous item in progress");

    // when idle only the closing byte of the last item can still wait
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_tready && o_m_tvalid) |-> o_m_tlast)
        else $error("idle with a non-final output byte outstanding");

    // no raw control characters ever leave the block
    a_no_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata >= 8'h20))
        else $error("unescaped control byte on output");

endmodule

bind json_string_escaper_utf8 jse_checker u_jse_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam logic REQ_BYTE = 1'b0;   // one byte of the string
    localparam logic REQ_END  = 1'b1;   // end of the string

    localparam logic [7:0] CTL_BS    = 8'h08;
    localparam logic [7:0] CTL_TAB   = 8'h09;
    localparam logic [7:0] CTL_LF    = 8'h0a;
    localparam logic [7:0] CTL_FF    = 8'h0c;
    localparam logic [7:0] CTL_CR    = 8'h0d;
    localparam logic [7:0] CTL_SPACE = 8'h20;
    localparam logic [7:0] UTF_TOP   = 8'h80;

    localparam int MAX_BYTES_PER_ITEM = 24;
    localparam int PHASE_ITEMS        = 44;
    localparam int HOLD_CYCLES        = 400;
    localparam int DRAIN_CYCLES       = 40;
    localparam int WATCHDOG_LIMIT     = 4000;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last;
    } t_json_byte;

    // expected JSON text, worked out from each accepted item
    class escape_scoreboard;
        logic [7:0] held[3];
        int         held_n;
        bit         in_string;
        t_json_byte item_bytes[$];
        t_json_byte awaited[$];
        int         errors;
        string      hex_digits;

        function new();
            held_n     = 0;
            in_string  = 0;
            errors     = 0;
            hex_digits = "0123456789abcdef";
        endfunction

        function void put(logic [7:0] b);
            t_json_byte r;
            r.text_byte = b;
            r.last      = 1'b0;
            if (item_bytes.size() < MAX_BYTES_PER_ITEM) begin
                item_bytes.insert(item_bytes.size(), r);
            end
        endfunction

        function void put_repl();
            put(jse_pkg::CH_BSL);
            put(jse_pkg::CH_U);
            put(jse_pkg::CH_F);
            put(jse_pkg::CH_F);
            put(jse_pkg::CH_F);
            put(jse_pkg::CH_D);
        endfunction

        function void put_ascii(logic [7:0] b);
            logic [7:0] letter;
            case (b)
                jse_pkg::CH_QUOTE, jse_pkg::CH_BSL, jse_pkg::CH_SLASH: letter = b;
                CTL_BS:  letter = jse_pkg::CH_B;
                CTL_FF:  letter = jse_pkg::CH_F;
                CTL_LF:  letter = jse_pkg::CH_N;
                CTL_CR:  letter = jse_pkg::CH_R;
                CTL_TAB: letter = jse_pkg::CH_T;
                default: letter = 8'h00;
            endcase
            if (letter != 8'h00) begin
                put(jse_pkg::CH_BSL);
                put(letter);
            end else if (b < CTL_SPACE) begin
                put(jse_pkg::CH_BSL);
                put(jse_pkg::CH_U);
                put(jse_pkg::CH_ZERO);
                put(jse_pkg::CH_ZERO);
                put(hex_digits[b[7:4]]);
                put(hex_digits[b[3:0]]);
            end else begin
                put(b);
            end
        endfunction

        function int lead_len(logic [7:0] b);
            if (b >= 8'hc2 && b <= 8'hdf) return 2;
            if (b >= 8'he0 && b <= 8'hef) return 3;
            if (b >= 8'hf0 && b <= 8'hf4) return 4;
            return 0;
        endfunction

        function bit cont_fits(logic [7:0] lead, bit second, logic [7:0] b);
            if (second && lead == jse_pkg::LEAD_E0) return b >= 8'ha0 && b <= 8'hbf;
            if (second && lead == jse_pkg::LEAD_ED) return b >= 8'h80 && b <= 8'h9f;
            if (second && lead == jse_pkg::LEAD_F0) return b >= 8'h90 && b <= 8'hbf;
            if (second && lead == jse_pkg::LEAD_F4) return b >= 8'h80 && b <= 8'h8f;
            return b >= 8'h80 && b <= 8'hbf;
        endfunction

        // walk the byte queue; an unfinished sequence is held unless flushing
        function void drain(logic [7:0] q[4], int n, bit flush);
            int         idx;
            int         need;
            int         avail;
            int         lim;
            int         k;
            logic [7:0] b;
            bit         bad;
            bit         stop;
            idx    = 0;
            held_n = 0;
            stop   = 0;
            while (idx < n && !stop) begin
                b = q[idx];
                if (b < UTF_TOP) begin
                    put_ascii(b);
                    idx++;
                end else begin
                    need  = lead_len(b);
                    avail = n - idx;
                    lim   = (avail < need) ? avail : need;
                    bad   = (need == 0);
                    for (k = 1; k < lim && !bad; k++) begin
                        if (!cont_fits(b, k == 1, q[idx + k])) bad = 1;
                    end
                    if (bad || (avail < need && flush)) begin
                        // bad lead or cut-short sequence: replacement, then look again from the next byte
                        put_repl();
                        idx++;
                    end else if (avail >= need) begin
                        for (k = 0; k < need; k++) put(q[idx + k]);
                        idx += need;
                    end else begin
                        for (k = 0; k < avail; k++) held[k] = q[idx + k];
                        held_n = avail;
                        stop   = 1;
                    end
                end
            end
        endfunction

        function void note_input(logic req, logic [7:0] data);
            logic [7:0] q[4];
            int         n;
            int         i;
            t_json_byte tail;
            item_bytes.delete();
            if (!in_string) begin
                put(jse_pkg::CH_QUOTE);
                in_string = 1;
            end
            n = 0;
            for (i = 0; i < held_n; i++) begin
                q[n] = held[i];
                n++;
            end
            if (req == REQ_BYTE) begin
                q[n] = data;
                n++;
                drain(q, n, 0);
            end else begin
                drain(q, n, 1);
                put(jse_pkg::CH_QUOTE);
                in_string = 0;
                held_n    = 0;
            end
            if (item_bytes.size() > 0) begin
                tail      = item_bytes.pop_back();
                tail.last = 1'b1;
                item_bytes.insert(item_bytes.size(), tail);
            end
            for (i = 0; i < item_bytes.size(); i++) begin
                awaited.insert(awaited.size(), item_bytes[i]);
            end
        endfunction

        function void check_result(logic [7:0] b, logic last);
            t_json_byte want;
            if (awaited.size() == 0) begin
                $error("result with nothing expected: out_byte %h run_last %b", b, last);
                errors++;
            end else begin
                want = awaited.pop_front();
                if (b !== want.text_byte) begin
                    $error("out_byte: expected %h, got %h", want.text_byte, b);
                    errors++;
                end
                if (last !== want.last) begin
                    $error("run_last: expected %b, got %b", want.last, last);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'h00;   // [7:0] data_byte
    logic       i_s_tuser  = 1'b0;    // [0] req_type
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;            // [7:0] out_byte
    logic       o_m_tlast;

    escape_scoreboard sb;
    logic [7:0]       text_q[$];
    int               src_idle_pct   = 0;
    int               sink_stall_pct = 0;
    int               items_sent     = 0;
    int               quiet_cycles   = 0;
    bit               hold_req       = 0;

    json_string_escaper_utf8 uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tlast);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("** json_string_escaper_utf8: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic req, input logic [7:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= req;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_input(req, data);
        items_sent++;
    endtask

    // the bytes in text_q, then the end marker with a random don't-care byte
    task automatic send_text();
        int k;
        for (k = 0; k < text_q.size(); k++) send_item(REQ_BYTE, text_q[k]);
        send_item(REQ_END, 8'($urandom_range(255)));
    endtask

    // one character: mostly well-formed, some broken sequences and noise
    function automatic void add_random_char();
        logic [7:0] seq[4];
        int         len;
        int         k;
        int         r;
        r   = $urandom_range(99);
        len = 1;
        if (r < 35) begin
            seq[0] = 8'($urandom_range(8'h20, 8'h7e));
        end else if (r < 45) begin
            case ($urandom_range(3))
                0:       seq[0] = jse_pkg::CH_QUOTE;
                1:       seq[0] = jse_pkg::CH_BSL;
                2:       seq[0] = jse_pkg::CH_SLASH;
                default: seq[0] = 8'($urandom_range(8'h1f));
            endcase
        end else if (r < 89) begin
            len = (r < 57) ? 2 : (r < 69) ? 3 : (r < 79) ? 4 : $urandom_range(2, 4);
            case (len)
                2: seq[0] = 8'($urandom_range(8'hc2, 8'hdf));
                3: seq[0] = ($urandom_range(2) == 0) ?
                            (($urandom_range(1) == 0) ? jse_pkg::LEAD_E0 : jse_pkg::LEAD_ED) :
                            8'($urandom_range(8'he0, 8'hef));
                default: seq[0] = ($urandom_range(2) == 0) ?
                                  (($urandom_range(1) == 0) ? jse_pkg::LEAD_F0 :
                                                              jse_pkg::LEAD_F4) :
                                  8'($urandom_range(8'hf0, 8'hf4));
            endcase
            case (seq[0])
                jse_pkg::LEAD_E0: seq[1] = 8'($urandom_range(8'ha0, 8'hbf));
                jse_pkg::LEAD_ED: seq[1] = 8'($urandom_range(8'h80, 8'h9f));
                jse_pkg::LEAD_F0: seq[1] = 8'($urandom_range(8'h90, 8'hbf));
                jse_pkg::LEAD_F4: seq[1] = 8'($urandom_range(8'h80, 8'h8f));
                default:          seq[1] = 8'($urandom_range(8'h80, 8'hbf));
            endcase
            for (k = 2; k < len; k++) seq[k] = 8'($urandom_range(8'h80, 8'hbf));
            if (r >= 79) begin
                // cut short or spoil one continuation
                if ($urandom_range(1) == 0) len = $urandom_range(1, len - 1);
                else seq[$urandom_range(1, len - 1)] = 8'($urandom_range(255));
            end
        end else begin
            seq[0] = 8'($urandom_range(255));
        end
        for (k = 0; k < len; k++) text_q.insert(text_q.size(), seq[k]);
    endfunction

    task automatic run_phase(input int src_pct, input int sink_pct, input int n_items);
        int start;
        int n_chars;
        int k;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start          = items_sent;
        while (items_sent - start < n_items) begin
            text_q.delete();
            n_chars = $urandom_range(0, 6);
            for (k = 0; k < n_chars; k++) add_random_char();
            send_text();
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty string, with the don't-care byte all ones
        text_q.delete();
        send_item(REQ_END, 8'hff);
        // every ascii escape and the ascii extremes
        text_q = '{8'h00, jse_pkg::CH_QUOTE, jse_pkg::CH_BSL, jse_pkg::CH_SLASH, CTL_BS,
                   CTL_FF, CTL_LF, CTL_CR, CTL_TAB, 8'h1f, 8'h7f};
        send_text();
        // utf-8 extremes, bad lead, broken sequence, sequence cut by the end marker
        text_q = '{8'hc2, 8'hbf, jse_pkg::LEAD_F4, 8'h8f, 8'hbf, 8'hbf, 8'hff,
                   jse_pkg::LEAD_E0, 8'h80, jse_pkg::LEAD_F0, 8'h90};
        send_text();

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(67, 0, PHASE_ITEMS);
        run_phase(0, 67, PHASE_ITEMS);
        run_phase(16, 16, PHASE_ITEMS);

        // receiver holds off while the sender keeps offering items
        hold_req = 1;
        run_phase(0, 0, 20);
        i_s_tvalid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("** json_string_escaper_utf8: PASSED **");
        end else begin
            $display("** json_string_escaper_utf8: FAILED **");
        end
        $finish;
    end

endmodule
